### hw/rtl/home_computer_bank_decoder_macros.svh
// Assertion helpers for the bank decoder.
`ifndef HOME_COMPUTER_BANK_DECODER_MACROS_SVH
`define HOME_COMPUTER_BANK_DECODER_MACROS_SVH

// Same-cycle implication.
`define HCBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hcbd_pkg.sv
`timescale 1ns / 1ps

package hcbd_pkg;

    typedef enum logic [3:0] {
        TGT_RAM_READ   = 4'd0,
        TGT_RAM_WRITE  = 4'd1,
        TGT_VIDEO_BANK = 4'd2,
        TGT_PAGE_39    = 4'd3,
        TGT_PAGE_3F    = 4'd4,
        TGT_TOP_PAGE   = 4'd5,
        TGT_BASIC      = 4'd6,
        TGT_CHARGEN    = 4'd7,
        TGT_KERNAL     = 4'd8,
        TGT_VIC        = 4'd9,
        TGT_SID        = 4'd10,
        TGT_COLOR      = 4'd11,
        TGT_CIA1       = 4'd12,
        TGT_CIA2       = 4'd13,
        TGT_EXP_IO     = 4'd14,
        TGT_PORT       = 4'd15
    } hcbd_tgt_t;

    localparam logic [1:0] CFG_TAPE_BUTTON = 2'd0;
    localparam logic [1:0] CFG_VIDEO_BANK  = 2'd1;
    localparam logic [1:0] CFG_DMA_ENABLE  = 2'd2;

    localparam logic [15:0] DMA_START_ADDR = 16'hff00;
    localparam logic [15:0] MASK_8K        = 16'h1fff;
    localparam logic [15:0] MASK_4K        = 16'h0fff;
    localparam logic [7:0]  IMG_MASK       = 8'h3f;
    localparam logic [7:0]  IMG_MASK_TAPE  = 8'h2f;
    localparam logic [7:0]  PORT_DIR_RST   = 8'h00;
    localparam logic [7:0]  PORT_VAL_RST   = 8'hff;
    localparam logic [2:0]  LAYOUT_IO_MIN  = 3'd5;
    localparam logic [2:0]  LAYOUT_BASIC_A = 3'd3;
    localparam logic [2:0]  LAYOUT_BASIC_B = 3'd7;
    localparam logic [2:0]  LAYOUT_CHR_MIN = 3'd1;
    localparam logic [2:0]  LAYOUT_CHR_MAX = 3'd3;

    typedef struct packed {
        logic       tape_button;
        logic [1:0] video_bank;
        logic       dma_enable;
    } hcbd_cfg_t;

    typedef struct packed {
        logic       wr;
        logic [15:0] address;
        logic [7:0] write_data;
        logic       is_port;
        logic       zero_page;
        logic       top_page;
        logic       basic_area;
        logic       io_area;
        logic       kernal_area;
        logic       page_39;
        logic       page_3f;
        logic       dma_addr;
        hcbd_tgt_t  io_tgt;
    } hcbd_item_t;

    function automatic hcbd_tgt_t io_target(input logic [7:0] page);
        hcbd_tgt_t t;
        if (page <= 8'hd3)      t = TGT_VIC;
        else if (page <= 8'hd7) t = TGT_SID;
        else if (page <= 8'hdb) t = TGT_COLOR;
        else if (page == 8'hdc) t = TGT_CIA1;
        else if (page == 8'hdd) t = TGT_CIA2;
        else                    t = TGT_EXP_IO;
        return t;
    endfunction

endpackage

### hw/rtl/hcbd_front.sv
`timescale 1ns / 1ps

module hcbd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_wr,
    input  logic [15:0]         in_address,
    input  logic [7:0]          in_write_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hcbd_pkg::hcbd_item_t out_item
);

    logic                 valid_reg, valid_next;
    hcbd_pkg::hcbd_item_t item_reg, item_next;
    logic [7:0]           page;

    assign page     = in_address[15:8];
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next             = item_reg;
        item_next.wr          = in_wr;
        item_next.address     = in_address;
        item_next.write_data  = in_write_data;
        item_next.is_port     = (in_address[15:1] == 15'd0);
        item_next.zero_page   = (page == 8'h00);
        item_next.top_page    = (page == 8'hff);
        item_next.basic_area  = (page >= 8'ha0) && (page <= 8'hbf);
        item_next.io_area     = (page[7:4] == 4'hd);
        item_next.kernal_area = (page >= 8'he0);
        item_next.page_39     = (page == 8'h39);
        item_next.page_3f     = (page == 8'h3f);
        item_next.dma_addr    = (in_address == hcbd_pkg::DMA_START_ADDR);
        item_next.io_tgt      = hcbd_pkg::io_target(page);
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### hw/rtl/hcbd_queue.sv
`timescale 1ns / 1ps

module hcbd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hcbd_pkg::hcbd_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hcbd_pkg::hcbd_item_t out_item
);

    hcbd_pkg::hcbd_item_t slot_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### hw/rtl/hcbd_back.sv
`timescale 1ns / 1ps

module hcbd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hcbd_pkg::hcbd_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hcbd_pkg::hcbd_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hcbd_pkg::hcbd_tgt_t  out_target,
    output logic [15:0]          out_offset,
    output logic [7:0]           out_read_data,
    output logic [7:0]           out_data_out,
    output logic [2:0]           out_layout,
    output logic                 out_dma_start
);

    logic                valid_reg, valid_next;
    logic [7:0]          dir_reg, dir_next;
    logic [7:0]          val_reg, val_next;
    hcbd_pkg::hcbd_tgt_t target_reg, target_next;
    logic [15:0]         offset_reg, offset_next;
    logic [7:0]          rdata_reg, rdata_next;
    logic [7:0]          dout_reg, dout_next;
    logic [2:0]          layout_reg, layout_next;
    logic                dma_reg, dma_next;
    logic [2:0]          layout_cur;
    logic                io_on;
    logic                pop;

    assign in_ready   = !valid_reg || out_ready;
    assign pop        = in_valid && in_ready;
    assign layout_cur = ~dir_reg[2:0] | val_reg[2:0];
    assign io_on      = (layout_cur >= hcbd_pkg::LAYOUT_IO_MIN);

    always_comb begin
        dir_next    = dir_reg;
        val_next    = val_reg;
        target_next = hcbd_pkg::TGT_RAM_READ;
        offset_next = in_item.address;
        rdata_next  = 8'h00;
        dma_next    = 1'b0;
        dout_next   = in_item.wr ? in_item.write_data : 8'h00;

        if (in_item.is_port) begin
            target_next = hcbd_pkg::TGT_PORT;
            if (in_item.wr) begin
                if (!in_item.address[0]) begin
                    dir_next = in_item.write_data;
                end else begin
                    val_next = in_item.write_data;
                end
            end else if (!in_item.address[0]) begin
                rdata_next = dir_reg;
            end else begin
                rdata_next = (val_reg | ~dir_reg) & (cfg.tape_button ?
                             hcbd_pkg::IMG_MASK_TAPE : hcbd_pkg::IMG_MASK);
            end
        end else if (in_item.wr) begin
            if (in_item.zero_page) begin
                target_next = hcbd_pkg::TGT_RAM_WRITE;
            end else if (in_item.top_page) begin
                target_next = hcbd_pkg::TGT_TOP_PAGE;
                dma_next    = cfg.dma_enable && in_item.dma_addr;
            end else if (io_on && in_item.io_area) begin
                target_next = in_item.io_tgt;
            end else if (in_item.address[15:14] == cfg.video_bank) begin
                if (in_item.page_39) begin
                    target_next = hcbd_pkg::TGT_PAGE_39;
                end else if (in_item.page_3f) begin
                    target_next = hcbd_pkg::TGT_PAGE_3F;
                end else begin
                    target_next = hcbd_pkg::TGT_VIDEO_BANK;
                end
            end else begin
                target_next = hcbd_pkg::TGT_RAM_WRITE;
            end
        end else begin
            if (in_item.basic_area && (layout_cur == hcbd_pkg::LAYOUT_BASIC_A ||
                                       layout_cur == hcbd_pkg::LAYOUT_BASIC_B)) begin
                target_next = hcbd_pkg::TGT_BASIC;
                offset_next = in_item.address & hcbd_pkg::MASK_8K;
            end else if (in_item.io_area) begin
                if (io_on) begin
                    target_next = in_item.io_tgt;
                end else if (layout_cur >= hcbd_pkg::LAYOUT_CHR_MIN &&
                             layout_cur <= hcbd_pkg::LAYOUT_CHR_MAX) begin
                    target_next = hcbd_pkg::TGT_CHARGEN;
                    offset_next = in_item.address & hcbd_pkg::MASK_4K;
                end
            end else if (in_item.kernal_area && layout_cur[1]) begin
                target_next = hcbd_pkg::TGT_KERNAL;
                offset_next = in_item.address & hcbd_pkg::MASK_8K;
            end
        end

        layout_next = ~dir_next[2:0] | val_next[2:0];
    end

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dir_reg   <= hcbd_pkg::PORT_DIR_RST;
            val_reg   <= hcbd_pkg::PORT_VAL_RST;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                dir_reg <= dir_next;
                val_reg <= val_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            target_reg <= target_next;
            offset_reg <= offset_next;
            rdata_reg  <= rdata_next;
            dout_reg   <= dout_next;
            layout_reg <= layout_next;
            dma_reg    <= dma_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_target    = target_reg;
    assign out_offset    = offset_reg;
    assign out_read_data = rdata_reg;
    assign out_data_out  = dout_reg;
    assign out_layout    = layout_reg;
    assign out_dma_start = dma_reg;

endmodule

### hw/rtl/home_computer_bank_decoder.sv
// Bus access decoder for a 6510-style home computer with a PLA memory map. Each
// transaction on the s_ side is one CPU read or write; the m_ side returns one
// transaction naming the target device or memory, the offset within it, the
// processor port read data and the layout in force after the access. Sustained
// rate is one transaction per cycle while m_tready stays high. From s_ acceptance
// to m_tvalid a transaction passes a classify register, a two-entry queue and the
// decode output register, the last of which also holds the processor port state.
// Reset leaves the port at direction $00 and data $FF (layout 7). Write cfg_* only
// while no transaction is in flight.
`timescale 1ns / 1ps

module home_computer_bank_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  logic        s_tuser,   // kind (0 read, 1 write)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // offset[15:0], read_data[23:16], data_out[31:24],
                                   // layout[34:32], dma_start[35], zero[39:36]
    output logic [3:0]  m_tuser,   // target[3:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

`include "home_computer_bank_decoder_macros.svh"

    hcbd_pkg::hcbd_cfg_t  cfg_reg, cfg_next;
    logic                 fr_valid, q_in_ready;
    hcbd_pkg::hcbd_item_t fr_item;
    logic                 q_valid, bk_ready;
    hcbd_pkg::hcbd_item_t q_item;
    hcbd_pkg::hcbd_tgt_t  bk_target;
    logic [15:0]          bk_offset;
    logic [7:0]           bk_read_data;
    logic [7:0]           bk_data_out;
    logic [2:0]           bk_layout;
    logic                 bk_dma_start;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                hcbd_pkg::CFG_TAPE_BUTTON: cfg_next.tape_button = cfg_data[0];
                hcbd_pkg::CFG_VIDEO_BANK:  cfg_next.video_bank  = cfg_data;
                hcbd_pkg::CFG_DMA_ENABLE:  cfg_next.dma_enable  = cfg_data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hcbd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_wr         (s_tuser),
        .in_address    (s_tdata[15:0]),
        .in_write_data (s_tdata[23:16]),
        .out_valid     (fr_valid),
        .out_ready     (q_in_ready),
        .out_item      (fr_item)
    );

    hcbd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (q_in_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (bk_ready),
        .out_item  (q_item)
    );

    hcbd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (q_valid),
        .in_ready      (bk_ready),
        .in_item       (q_item),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_target    (bk_target),
        .out_offset    (bk_offset),
        .out_read_data (bk_read_data),
        .out_data_out  (bk_data_out),
        .out_layout    (bk_layout),
        .out_dma_start (bk_dma_start)
    );

    assign m_tuser = bk_target;
    assign m_tdata = {4'd0, bk_dma_start, bk_layout, bk_data_out, bk_read_data, bk_offset};

    `HCBD_ASSERT_NOW(a_dma_top_page, m_tvalid && bk_dma_start, bk_target == hcbd_pkg::TGT_TOP_PAGE, "dma start outside top page")
    `HCBD_ASSERT_NOW(a_rdata_port, m_tvalid && bk_read_data != 8'h00, bk_target == hcbd_pkg::TGT_PORT, "read data on non-port target")
    `HCBD_ASSERT_NOW(a_chargen_off, m_tvalid && bk_target == hcbd_pkg::TGT_CHARGEN, bk_offset[15:12] == 4'h0, "chargen offset beyond 4K")
    `HCBD_ASSERT_NEXT(a_front_hold, fr_valid && !q_in_ready, fr_valid, "classified transaction dropped")

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import hcbd_pkg::*;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;
    localparam int   NUM_DIRECTED = 25;
    localparam int   NUM_PHASES = 6;
    localparam int   PHASE_ITEMS = 140;
    localparam int   DRAIN_CYCLES = 6;
    localparam int   CYCLE_LIMIT = 300000;

    typedef struct {
        logic       kind;
        logic [15:0] addr;
        logic [7:0] wdata;
        logic       typed;
        hcbd_tgt_t  tgt;
        logic [15:0] offset;
        logic [7:0] rdata;
    } access_row_t;

    typedef struct {
        hcbd_tgt_t  target;
        logic [15:0] offset;
        logic [7:0] read_data;
        logic [7:0] data_out;
        logic [2:0] layout;
        logic       dma_start;
    } bus_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [1:0]  cfg_data = '0;

    logic [7:0]  port_dir;
    logic [7:0]  port_val;
    logic        tape_pressed;
    logic [1:0]  video_bank;
    logic        dma_enabled;

    bus_result_t expected_results[$];
    access_row_t directed_rows [0:NUM_DIRECTED-1];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          stall_pct = 0;

    home_computer_bank_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("home_computer_bank_decoder verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic logic [2:0] active_layout();
        logic [7:0] img;
        img = ~port_dir | port_val;
        return img[2:0];
    endfunction

    function automatic hcbd_tgt_t io_device(input logic [7:0] page);
        hcbd_tgt_t t;
        case (page[3:0])
            4'h0, 4'h1, 4'h2, 4'h3: t = TGT_VIC;
            4'h4, 4'h5, 4'h6, 4'h7: t = TGT_SID;
            4'h8, 4'h9, 4'ha, 4'hb: t = TGT_COLOR;
            4'hc:                   t = TGT_CIA1;
            4'hd:                   t = TGT_CIA2;
            default:                t = TGT_EXP_IO;
        endcase
        return t;
    endfunction

    function automatic bus_result_t predict_access(input logic kind, input logic [15:0] addr,
                                                   input logic [7:0] wdata);
        bus_result_t r;
        logic [7:0]  page;
        logic [2:0]  lay;
        logic        io_on;
        page = addr[15:8];
        lay = active_layout();
        io_on = (lay >= 3'd5);
        r.target = TGT_RAM_READ;
        r.offset = addr;
        r.read_data = 8'h00;
        r.data_out = (kind == ACC_WRITE) ? wdata : 8'h00;
        r.dma_start = 1'b0;
        if (addr <= 16'h0001) begin
            r.target = TGT_PORT;
            if (kind == ACC_WRITE) begin
                if (addr[0]) port_val = wdata;
                else port_dir = wdata;
            end else if (!addr[0]) begin
                r.read_data = port_dir;
            end else begin
                r.read_data = (port_val | ~port_dir) & (tape_pressed ? 8'h2f : 8'h3f);
            end
        end else if (kind == ACC_WRITE) begin
            if (page == 8'h00) begin
                r.target = TGT_RAM_WRITE;
            end else if (page == 8'hff) begin
                r.target = TGT_TOP_PAGE;
                r.dma_start = dma_enabled && (addr == 16'hff00);
            end else if (io_on && page[7:4] == 4'hd) begin
                r.target = io_device(page);
            end else if (page[7:6] == video_bank) begin
                if (page == 8'h39) r.target = TGT_PAGE_39;
                else if (page == 8'h3f) r.target = TGT_PAGE_3F;
                else r.target = TGT_VIDEO_BANK;
            end else begin
                r.target = TGT_RAM_WRITE;
            end
        end else begin
            if (page[7:5] == 3'b101 && (lay == 3'd3 || lay == 3'd7)) begin
                r.target = TGT_BASIC;
                r.offset = addr & 16'h1fff;
            end else if (page[7:4] == 4'hd) begin
                if (io_on) begin
                    r.target = io_device(page);
                end else if (lay >= 3'd1 && lay <= 3'd3) begin
                    r.target = TGT_CHARGEN;
                    r.offset = addr & 16'h0fff;
                end
            end else if (page >= 8'he0 && lay[1]) begin
                r.target = TGT_KERNAL;
                r.offset = addr & 16'h1fff;
            end
        end
        r.layout = active_layout();
        return r;
    endfunction

    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        logic [1:0]  bank;
        a = 16'($urandom);
        bank = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0: a = 16'($urandom_range(0, 1));
            1: a = {8'h00, a[7:0]};
            2: a = {8'hff, a[7:0]};
            3: a = 16'hff00;
            4: a = {4'hd, a[11:0]};
            5: a = {3'b101, a[12:0]};
            6: a = {3'b111, a[12:0]};
            7: a = {bank, ($urandom_range(0, 1) != 0) ? 6'h39 : 6'h3f, a[7:0]};
            default: ;
        endcase
        return a;
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        bus_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected transaction, target", m_tuser, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.target) note_mismatch("target", m_tuser, want.target);
                if (m_tdata[15:0] !== want.offset) note_mismatch("offset", m_tdata[15:0], want.offset);
                if (m_tdata[23:16] !== want.read_data)
                    note_mismatch("read_data", m_tdata[23:16], want.read_data);
                if (m_tdata[31:24] !== want.data_out)
                    note_mismatch("data_out", m_tdata[31:24], want.data_out);
                if (m_tdata[34:32] !== want.layout) note_mismatch("layout", m_tdata[34:32], want.layout);
                if (m_tdata[35] !== want.dma_start) note_mismatch("dma_start", m_tdata[35], want.dma_start);
            end
        end
    end

    task automatic write_settings(input logic tape, input logic [1:0] bank, input logic dma);
        logic [1:0] idx [3];
        logic [1:0] val [3];
        idx = '{CFG_TAPE_BUTTON, CFG_VIDEO_BANK, CFG_DMA_ENABLE};
        val = '{{1'b0, tape}, bank, {1'b0, dma}};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx[i])
                CFG_TAPE_BUTTON: tape_pressed = val[i][0];
                CFG_VIDEO_BANK:  video_bank = val[i];
                CFG_DMA_ENABLE:  dma_enabled = val[i][0];
                default: ;
            endcase
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_access(input access_row_t row);
        bus_result_t r;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= row.kind;
        s_tdata <= {row.wdata, row.addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_access(row.kind, row.addr, row.wdata);
        if (row.typed) begin
            r.target = row.tgt;
            r.offset = row.offset;
            r.read_data = row.rdata;
        end
        expected_results.push_back(r);
        @(negedge aclk);
    endtask

    task automatic drain_and_hold();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        access_row_t row;
        logic        tape;
        logic [1:0]  bank;
        logic        dma;
        port_dir = 8'h00;
        port_val = 8'hff;
        tape_pressed = 1'b0;
        video_bank = 2'd0;
        dma_enabled = 1'b0;
        directed_rows = '{
            '{ACC_READ,  16'h0000, 8'h00, 1'b1, TGT_PORT,     16'h0000, 8'h00},
            '{ACC_READ,  16'h0001, 8'h00, 1'b1, TGT_PORT,     16'h0001, 8'h2f},
            '{ACC_READ,  16'ha000, 8'h00, 1'b1, TGT_BASIC,    16'h0000, 8'h00},
            '{ACC_READ,  16'hffff, 8'h00, 1'b1, TGT_KERNAL,   16'h1fff, 8'h00},
            '{ACC_READ,  16'hd000, 8'h00, 1'b1, TGT_VIC,      16'hd000, 8'h00},
            '{ACC_WRITE, 16'hff00, 8'hff, 1'b1, TGT_TOP_PAGE, 16'hff00, 8'h00},
            '{ACC_WRITE, 16'h3900, 8'ha5, 1'b1, TGT_PAGE_39,  16'h3900, 8'h00},
            '{ACC_WRITE, 16'h3fff, 8'h5a, 1'b1, TGT_PAGE_3F,  16'h3fff, 8'h00},
            '{ACC_WRITE, 16'h1234, 8'h00, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_WRITE, 16'h0002, 8'hff, 1'b1, TGT_RAM_WRITE, 16'h0002, 8'h00},
            '{ACC_WRITE, 16'hd400, 8'h80, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_WRITE, 16'hdc00, 8'h01, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_WRITE, 16'hddff, 8'h02, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_READ,  16'hde00, 8'h00, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_READ,  16'hd800, 8'h00, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_WRITE, 16'h0000, 8'h07, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_WRITE, 16'h0001, 8'h00, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_READ,  16'ha000, 8'h00, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_READ,  16'hd000, 8'h00, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_WRITE, 16'h0001, 8'h01, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_READ,  16'hdfff, 8'h00, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_WRITE, 16'h0001, 8'h02, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_READ,  16'he000, 8'h00, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_WRITE, 16'h0001, 8'h06, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00},
            '{ACC_READ,  16'h0001, 8'h00, 1'b0, TGT_RAM_READ, 16'h0000, 8'h00}
        };

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_settings(1'b1, 2'd0, 1'b1);
        for (int i = 0; i < NUM_DIRECTED; i++) send_access(directed_rows[i]);
        drain_and_hold();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 59; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 59; end
                default: begin sender_idle_pct = 13; stall_pct = 13; end
            endcase
            case (p)
                0: begin tape = 1'b0; bank = 2'd0; dma = 1'b0; end
                1: begin tape = 1'b1; bank = 2'd3; dma = 1'b1; end
                2: begin tape = 1'b0; bank = 2'd1; dma = 1'b1; end
                3: begin tape = 1'b1; bank = 2'd2; dma = 1'b0; end
                default: begin
                    tape = 1'($urandom_range(0, 1));
                    bank = 2'($urandom_range(0, 3));
                    dma = 1'($urandom_range(0, 1));
                end
            endcase
            write_settings(tape, bank, dma);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2) drain_and_hold();
                row.kind = 1'($urandom_range(0, 1));
                row.addr = pick_address();
                row.wdata = 8'($urandom);
                row.typed = 1'b0;
                row.tgt = TGT_RAM_READ;
                row.offset = 16'h0000;
                row.rdata = 8'h00;
                send_access(row);
            end
            drain_and_hold();
        end

        if (mismatch_count == 0) begin
            $display("home_computer_bank_decoder verification clean");
        end else begin
            $display("home_computer_bank_decoder verification failed");
        end
        $finish;
    end

endmodule
